// File: sv/fprsa_pkg.sv
`default_nettype none
package fprsa_pkg;
   localparam int unsigned FracW  = 23;
   localparam int unsigned ExpW   = 8;
   localparam int unsigned SigW   = FracW + 1;
   localparam logic [ExpW-1:0] ExpMax = 8'hff;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic     start_new_sum;
      word_type value_bits;
   } item_type;
endpackage
`default_nettype wire

// File: sv/fprsa_add.sv
`default_nettype none
module fprsa_add (
   input  fprsa_pkg::word_type acc_bits,
   input  fprsa_pkg::word_type val_bits,
   output fprsa_pkg::word_type sum_bits
);
   import fprsa_pkg::*;

   logic [ExpW-1:0]  ea, eb, ebig, esmall, d;
   logic             sa, sb, sbig, ssmall, take_a;
   logic [FracW-1:0] fbig, fsmall;
   logic [SigW-1:0]  lmag, sig_small, q;
   logic [5:0]       dc;
   logic [48:0]      ext;
   logic             rnd;
   logic [24:0]      rmag, mag, m25, m_norm;
   logic signed [25:0] lv, rv, total;
   logic             neg;
   logic [4:0]       p;
   logic [8:0]       e_eff;
   logic signed [10:0] ebias, ebias_n;
   logic [31:0]      sub_w;

   always_comb begin
      ea = acc_bits[30:23];
      eb = val_bits[30:23];
      sa = acc_bits[31];
      sb = val_bits[31];
      take_a = ea > eb;
      ebig   = take_a ? ea : eb;
      esmall = take_a ? eb : ea;
      sbig   = take_a ? sa : sb;
      ssmall = take_a ? sb : sa;
      fbig   = take_a ? acc_bits[22:0] : val_bits[22:0];
      fsmall = take_a ? val_bits[22:0] : acc_bits[22:0];
      lmag      = {(ebig != '0), fbig};
      sig_small = {(esmall != '0), fsmall};
      d  = ebig - esmall;
      dc = (d > 8'd63) ? 6'd63 : d[5:0];
      // align with round to nearest even
      ext  = {sig_small, 25'b0} >> dc;
      q    = ext[48:25];
      rnd  = ext[24] & ((|ext[23:0]) | q[0]);
      rmag = {1'b0, q} + {24'b0, rnd};
      lv = sbig ? -$signed({2'b0, lmag}) : $signed({2'b0, lmag});
      rv = ssmall ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      total = lv + rv;
      neg = total[25];
      mag = neg ? 25'(-total) : total[24:0];
      p = '0;
      for (int i = 0; i < 25; i++) begin
         if (mag[i]) p = 5'(i);
      end
      e_eff = (ebig == '0) ? 9'd1 : {1'b0, ebig};
      ebias = $signed({6'b0, p}) + $signed({2'b0, e_eff}) - 11'sd23;
      sub_w = {7'b0, mag} << (e_eff - 9'd1);
      if (p == 5'd24) begin
         m25 = {1'b0, mag[24:1]} + {24'b0, mag[0] & mag[1]};
      end else begin
         m25 = mag << (5'd23 - p);
      end
      if (m25[24]) begin
         m_norm  = m25 >> 1;
         ebias_n = ebias + 11'sd1;
      end else begin
         m_norm  = m25;
         ebias_n = ebias;
      end
      if (total == '0) begin
         sum_bits = {sa & sb, 31'b0};
      end else if (ebias < 11'sd1) begin
         sum_bits = {neg, 8'b0, sub_w[22:0]};
      end else if (ebias_n >= 11'sd255) begin
         sum_bits = {neg, ExpMax, 23'b0};
      end else begin
         sum_bits = {neg, ebias_n[7:0], m_norm[22:0]};
      end
   end
endmodule
`default_nettype wire

// File: sv/float_running_sum_accumulator.sv
// Running binary32 accumulator.
// Request channel: req_value_bits with req_start_new_sum, taken when
// req_valid is high and req_stall low. Each item yields one response on
// rsp_sum_bits, the sum after that item, taken when rsp_valid is high and
// rsp_stall low.
// Path: a request passes the input register, then the result register, before
// its response is valid. Throughput: one item per cycle while rsp_stall is low; the add against the
// stored sum is one pass of logic between the input register and the sum
// register.
// The first item after reset, or one with req_start_new_sum set, is loaded
// unchanged as the new sum.
// Reset (synchronous, active high) empties both registers and the sum.
// While the receiver stalls, the response holds and the input register
// holds its item; req_stall rises only once both are full.
`default_nettype none
module float_running_sum_accumulator (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  fprsa_pkg::word_type  req_value_bits,
   input  wire                  req_start_new_sum,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output fprsa_pkg::word_type  rsp_sum_bits
);
   import fprsa_pkg::*;

   logic     in_valid_ff, out_valid_ff, sum_empty_ff;
   item_type in_ff;
   word_type sum_ff, out_ff, add_res, sum_in;
   logic     out_free, advance, req_take;

   fprsa_add u_add (
      .acc_bits (sum_ff),
      .val_bits (in_ff.value_bits),
      .sum_bits (add_res)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign sum_in    = (in_ff.start_new_sum || sum_empty_ff) ? in_ff.value_bits : add_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sum_empty_ff <= 1'b1;
         sum_ff       <= '0;
      end else begin
         if (req_take) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) begin
            out_valid_ff <= 1'b1;
            sum_empty_ff <= 1'b0;
            sum_ff       <= sum_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_ff <= '{start_new_sum: req_start_new_sum, value_bits: req_value_bits};
      if (advance) out_ff <= sum_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sum_bits = out_ff;

`ifndef SYNTH
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted item not held in input register");
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> ($stable(in_ff) && in_valid_ff))
      else $error("input register changed while blocked");
   a_sum_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff == sum_ff && !sum_empty_ff))
      else $error("response differs from stored sum");
`endif
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import fprsa_pkg::*;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_value_bits = '0;
   logic     req_start_new_sum = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_sum_bits;

   float_running_sum_accumulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value_bits(req_value_bits), .req_start_new_sum(req_start_new_sum),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sum_bits(rsp_sum_bits)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   word_type acc_sum = '0;
   bit       acc_empty = 1'b1;
   word_type expected_sums[$];
   int       fail_count = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       hold_cycles = 0;

   function automatic logic [63:0] round_shift(logic [63:0] v, int s);
      logic [63:0] q, r, half;
      if (s == 0) return v;
      if (s > 63) return 0;
      q = v >> s;
      r = v & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (r > half || (r == half && q[0])) q++;
      return q;
   endfunction

   function automatic word_type pack_sum(logic sgn, logic [63:0] mag, int k);
      int p, x, sh, eb;
      logic [63:0] m;
      p = 0;
      if (mag == 0) return {sgn, 31'd0};
      while ((mag >> (p + 1)) != 0) p++;
      x = p + k;
      if (x < -126) begin
         sh = k + 149;
         m = (sh >= 0) ? (mag << sh) : round_shift(mag, -sh);
         return {sgn, 31'd0} | m[31:0];
      end
      m = (p > 23) ? round_shift(mag, p - 23) : (mag << (23 - p));
      eb = x + 127;
      if (m >= (64'd1 << 24)) begin
         m = m >> 1;
         eb++;
      end
      if (eb >= 255) return {sgn, 8'hff, 23'd0};
      return {sgn, eb[7:0], m[22:0]};
   endfunction

   function automatic word_type add_binary32(word_type a, word_type b);
      word_type big, lit;
      logic [63:0] lmag, rmag;
      longint total;
      int d, scale;
      if (a[30:23] > b[30:23]) begin
         big = a; lit = b;
      end else begin
         big = b; lit = a;
      end
      d = big[30:23] - lit[30:23];
      lmag = (big[30:23] == 0) ? {41'd0, big[22:0]} : {40'd0, 1'b1, big[22:0]};
      rmag = (lit[30:23] == 0) ? {41'd0, lit[22:0]} : {40'd0, 1'b1, lit[22:0]};
      rmag = round_shift(rmag, d > 40 ? 40 : d);
      total = (big[31] ? -longint'(lmag) : longint'(lmag))
            + (lit[31] ? -longint'(rmag) : longint'(rmag));
      if (total == 0) return {a[31] & b[31], 31'd0};
      scale = (big[30:23] == 0) ? -126 : int'(big[30:23]) - 127;
      if (total < 0) return pack_sum(1'b1, -total, scale - 23);
      return pack_sum(1'b0, total, scale - 23);
   endfunction

   task automatic send_value(word_type v, bit start);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value_bits <= v;
      req_start_new_sum <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (start || acc_empty) acc_sum = v;
      else acc_sum = add_binary32(acc_sum, v);
      acc_empty = 1'b0;
      expected_sums.push_back(acc_sum);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus a counted hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $error("unexpected result sum_bits=%h", rsp_sum_bits);
            fail_count++;
         end else begin
            if (rsp_sum_bits !== expected_sums[0]) begin
               $error("sum_bits expected %h actual %h", expected_sums[0], rsp_sum_bits);
               fail_count++;
            end
            void'(expected_sums.pop_front());
         end
      end
   end

   function automatic word_type rand_value();
      word_type v;
      v = $urandom();
      case ($urandom_range(5))
         0: v[30:23] = 8'($urandom_range(2));            // subnormal and near
         1: v[30:23] = 8'hfe - 8'($urandom_range(3));    // near overflow
         2: v[30:23] = 8'($urandom_range(120, 134));     // close exponents
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_value(32'h8000_0000, 1'b0);  // first term: negative zero kept
      send_value(32'h8000_0000, 1'b0);  // -0 + -0
      send_value(32'h0000_0000, 1'b0);
      send_value(32'h7fff_ffff, 1'b1);  // all-ones exponent loaded as is
      send_value(32'h3f80_0000, 1'b0);
      send_value(32'h7f7f_ffff, 1'b1);
      send_value(32'h7f7f_ffff, 1'b0);  // overflow
      send_value(32'hff7f_ffff, 1'b0);
      send_value(32'h0000_0001, 1'b1);
      send_value(32'h0080_0000, 1'b0);  // subnormal against field one
      send_value(32'h807f_ffff, 1'b0);
      send_value(32'h3f80_0000, 1'b1);
      send_value(32'hbf80_0000, 1'b0);  // exact cancel
      send_value(32'h3380_0000, 1'b0);  // small term added to a zero sum
      send_value(32'h3400_0001, 1'b0);
      send_value(32'hffff_ffff, 1'b0);
      send_value(32'h4b80_0001, 1'b1);
      send_value(32'hcb80_0000, 1'b0);
      go_idle();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_value(rand_value(), $urandom_range(15) == 0);
      go_idle();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 60;
      repeat (40) send_value(rand_value(), $urandom_range(7) == 0);
      go_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0, 0);
      test_random(500, 47, 0);
      test_random(500, 0, 47);
      test_random(500, 13, 13);
      test_backpressure();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_sums.size() == 0)
         $display("** float_running_sum_accumulator: PASSED **");
      else
         $display("** float_running_sum_accumulator: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** float_running_sum_accumulator: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
sv/fprsa_pkg.sv
sv/fprsa_add.sv
sv/float_running_sum_accumulator.sv
sim/tb_top.sv
